// ===== rtl/firmware_image_validator_macros.svh =====
// ----------------------------------------------------------------------------
// Firmware image validator assertion macros
// Concurrent check wrappers on clk with rst_n low disabling the check.
// ----------------------------------------------------------------------------
`ifndef FIRMWARE_IMAGE_VALIDATOR_MACROS_SVH
`define FIRMWARE_IMAGE_VALIDATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define FIV_AST_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("fiv check failed");
// next-cycle implication
`define FIV_AST_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("fiv check failed");
`else
`define FIV_AST_NOW(lbl, pre, post)
`define FIV_AST_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/fiv_pkg.sv =====
// ----------------------------------------------------------------------------
// fiv_pkg
// Types, codes and CRC-32 helpers shared by the firmware image validator.
// ----------------------------------------------------------------------------
`default_nettype none

package fiv_pkg;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // operation codes of the input item
  localparam logic [1:0] OP_LENGTH = 2'd0;
  localparam logic [1:0] OP_CRC    = 2'd1;
  localparam logic [1:0] OP_IMAGE  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APP_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SPAN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SPAN    = 3'd4;

  // verdict codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_CRC_BLANK  = 3'd1;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
  localparam logic [2:0] ST_MISMATCH   = 3'd3;
  localparam logic [2:0] ST_STACK      = 3'd4;
  localparam logic [2:0] ST_ENTRY      = 3'd5;
  localparam logic [2:0] ST_BLANK      = 3'd6;
  localparam logic [2:0] ST_SHORT      = 3'd7;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] data_word;
    logic        last;
  } fiv_in_t;

  typedef struct packed {
    logic        image_valid;
    logic [2:0]  status;
    logic [31:0] computed_crc;
    logic [31:0] app_length;
  } fiv_out_t;

  typedef enum logic [1:0] {
    KIND_LEN,
    KIND_CRC,
    KIND_IMG,
    KIND_NOP
  } kind_t;

  // classified item; word is the raw data word, range flags judged at accept
  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    logic        last;
    logic        stk_ok;
    logic        ent_ok;
    logic        prog;
  } fiv_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef logic [31:0][31:0] crc_mat_t;

  // column j: 32 reflected shift steps applied to a single set bit j
  function automatic crc_mat_t crc_mat_init();
    crc_mat_t    m;
    logic [31:0] a;
    for (int j = 0; j < 32; j++) begin
      a = 32'h1 << j;
      for (int i = 0; i < 32; i++) begin
        a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
      end
      m[j] = a;
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_MAT = crc_mat_init();

  // one 32-bit word through the CRC as a fixed XOR matrix
  function automatic logic [31:0] crc_step(logic [31:0] acc, logic [31:0] w);
    logic [31:0] x;
    logic [31:0] r;
    x = acc ^ w;
    r = '0;
    for (int j = 0; j < 32; j++) begin
      if (x[j]) begin
        r = r ^ CRC_MAT[j];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/firmware_image_validator.sv =====
// ----------------------------------------------------------------------------
// firmware_image_validator
// Streaming CRC-32 and sanity check of a stored firmware image.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_item): send the stored length word,
//   the stored CRC word, then image words from the region start; set last on
//   the final item. One item is taken per cycle while the four-entry queue
//   has room.
//   Output channel (out_valid/out_ready/out_item): one verdict per item
//   marked last, with status, computed CRC and validated length.
//   Path of a last item: queue, execute into snapshot, verdict into output.
//   Throughput: one item per cycle; the CRC is a single XOR matrix per word.
//   A last item waits in the queue only while the snapshot and output
//   register are both full and out_ready is low, so with out_ready low the
//   queue fills and in_ready drops once three more items sit behind it.
//   Reset (rst_n low, synchronous) restores register defaults, clears the
//   stream state, the queue and any pending verdict.
//   Configuration (cfg_we/cfg_index/cfg_wdata) is to be written by the user
//   only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "firmware_image_validator_macros.svh"

module firmware_image_validator import fiv_pkg::*; #(
  parameter int unsigned COUNT_WIDTH       = 20,
  parameter int unsigned BLANK_CHECK_WORDS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire fiv_in_t              in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fiv_out_t                  out_item
);

  q_status_t   q_stat;
  logic        push, pop;
  fiv_entry_t  push_entry, head;
  logic [31:0] region_size;

  fiv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .q_stat      (q_stat),
    .push        (push),
    .push_entry  (push_entry),
    .region_size (region_size)
  );

  fiv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  fiv_back #(
    .COUNT_WIDTH       (COUNT_WIDTH),
    .BLANK_CHECK_WORDS (BLANK_CHECK_WORDS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_stat      (q_stat),
    .region_size (region_size),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

  `FIV_AST_NOW(a_q_sane, 1'b1, !(q_stat.full && q_stat.empty))
  `FIV_AST_NOW(a_ready_full, !in_ready, q_stat.full)
  `FIV_AST_NEXT(a_push_lands, in_valid && in_ready, !q_stat.empty)
  `FIV_AST_NOW(a_verdict_flag, out_valid, out_item.image_valid == (out_item.status == ST_OK))

endmodule

`default_nettype wire

// ===== rtl/fiv_front.sv =====
// ----------------------------------------------------------------------------
// fiv_front
// Holds configuration, accepts input items and classifies them for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fiv_front import fiv_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire fiv_in_t              in_item,
  input  wire q_status_t            q_stat,
  output logic                      push,
  output fiv_entry_t                push_entry,
  output logic [31:0]               region_size
);

  logic [31:0] region_size_r, app_base_r, flash_span_r, ram_base_r, ram_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_size_r <= 32'd491520;
      app_base_r    <= 32'h0800_8000;
      flash_span_r  <= 32'h0010_0000;
      ram_base_r    <= 32'h2000_0000;
      ram_span_r    <= 32'h0002_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_SIZE: region_size_r <= cfg_wdata;
        CFG_APP_BASE:    app_base_r    <= cfg_wdata;
        CFG_FLASH_SPAN:  flash_span_r  <= cfg_wdata;
        CFG_RAM_BASE:    ram_base_r    <= cfg_wdata;
        CFG_RAM_SPAN:    ram_span_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [31:0] w;
  logic [32:0] ram_top, flash_top;

  assign w           = in_item.data_word;
  assign ram_top     = {1'b0, ram_base_r} + {1'b0, ram_span_r};
  assign flash_top   = {1'b0, app_base_r} + {1'b0, flash_span_r};
  assign region_size = region_size_r;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_entry.last   = in_item.last;
    push_entry.word   = w;
    push_entry.stk_ok = (w >= ram_base_r) && ({1'b0, w} <= ram_top);
    push_entry.ent_ok = (w >= app_base_r) && ({1'b0, w} < flash_top);
    push_entry.prog   = (w != ALL_ONES);
    unique case (in_item.operation)
      OP_LENGTH: push_entry.kind = KIND_LEN;
      OP_CRC:    push_entry.kind = KIND_CRC;
      OP_IMAGE:  push_entry.kind = KIND_IMG;
      default:   push_entry.kind = KIND_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fiv_queue.sv =====
// ----------------------------------------------------------------------------
// fiv_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fiv_queue import fiv_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire fiv_entry_t push_entry,
  input  wire logic       pop,
  output fiv_entry_t      head,
  output q_status_t       q_stat
);

  fiv_entry_t         slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign head         = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fiv_back.sv =====
// ----------------------------------------------------------------------------
// fiv_back
// Runs CRC and image checks per item, snapshots on last, forms the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module fiv_back import fiv_pkg::*; #(
  parameter int unsigned COUNT_WIDTH       = 20,
  parameter int unsigned BLANK_CHECK_WORDS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire fiv_entry_t  head,
  input  wire q_status_t   q_stat,
  input  wire logic [31:0] region_size,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output fiv_out_t         out_item
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [30:0]            BLANK_W = 31'(BLANK_CHECK_WORDS);

  // a length fits if it is not erased and leaves the length word free
  function automatic logic len_fits(logic [31:0] len, logic [31:0] region);
    return (len != ALL_ONES) && (({1'b0, len} + 33'd4) <= {1'b0, region});
  endfunction

  // stream state; the length is held raw and judged against the live region
  logic [31:0]            acc_r, acc_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [31:0]            hlen_r, hlen_nxt;
  logic [30:0]            hwords_r, hwords_nxt;
  logic [31:0]            hcrc_r, hcrc_nxt;
  logic                   stk_r, stk_nxt, ent_r, ent_nxt, prog_r, prog_nxt;
  logic [30:0]            words_cur;
  logic                   snap_len_ok;

  // verdict snapshot
  logic                   snap_v_r, snap_v_nxt;
  logic [31:0]            snap_acc_r, snap_vlen_r, snap_hcrc_r;
  logic [COUNT_WIDTH-1:0] snap_cnt_r;
  logic [30:0]            snap_words_r;
  logic                   snap_stk_r, snap_ent_r, snap_prog_r;

  logic     out_valid_r, out_valid_nxt;
  fiv_out_t out_r, verdict;
  logic     snap_moves, snap_free, fire, fire_last;

  assign snap_moves = snap_v_r && (!out_valid_r || out_ready);
  assign snap_free  = !snap_v_r || snap_moves;
  // a last item waits until the snapshot has room
  assign pop        = !q_stat.empty && (!head.last || snap_free);
  assign fire       = pop;
  assign fire_last  = fire && head.last;

  assign words_cur   = len_fits(hlen_r, region_size) ? hwords_r : '0;
  assign snap_len_ok = len_fits(hlen_nxt, region_size);

  always_comb begin
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    hlen_nxt   = hlen_r;
    hwords_nxt = hwords_r;
    hcrc_nxt   = hcrc_r;
    stk_nxt    = stk_r;
    ent_nxt    = ent_r;
    prog_nxt   = prog_r;
    case (head.kind)
      KIND_LEN: begin
        hlen_nxt   = head.word;
        hwords_nxt = {1'b0, head.word[31:2]} + 31'(|head.word[1:0]);
      end
      KIND_CRC: hcrc_nxt = head.word;
      KIND_IMG: begin
        // saturated counter: drop the word
        if (cnt_r != CNT_MAX) begin
          if (31'(cnt_r) < words_cur) begin
            acc_nxt = crc_step(acc_r, head.word);
          end
          if (cnt_r == '0) begin
            stk_nxt = head.stk_ok;
          end
          if (cnt_r == COUNT_WIDTH'(1)) begin
            ent_nxt = head.ent_ok;
          end
          if ((32'(cnt_r) < 32'(BLANK_CHECK_WORDS)) && head.prog) begin
            prog_nxt = 1'b1;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= ALL_ONES;
      cnt_r    <= '0;
      hlen_r   <= '0;
      hwords_r <= '0;
      hcrc_r   <= ALL_ONES;
      stk_r    <= 1'b0;
      ent_r    <= 1'b0;
      prog_r   <= 1'b0;
    end else if (fire_last) begin
      acc_r    <= ALL_ONES;
      cnt_r    <= '0;
      hlen_r   <= '0;
      hwords_r <= '0;
      hcrc_r   <= ALL_ONES;
      stk_r    <= 1'b0;
      ent_r    <= 1'b0;
      prog_r   <= 1'b0;
    end else if (fire) begin
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      hlen_r   <= hlen_nxt;
      hwords_r <= hwords_nxt;
      hcrc_r   <= hcrc_nxt;
      stk_r    <= stk_nxt;
      ent_r    <= ent_nxt;
      prog_r   <= prog_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_last) begin
      snap_acc_r   <= acc_nxt;
      snap_cnt_r   <= cnt_nxt;
      // invalid lengths count as zero
      snap_vlen_r  <= snap_len_ok ? hlen_nxt : '0;
      snap_words_r <= snap_len_ok ? hwords_nxt : '0;
      snap_hcrc_r  <= hcrc_nxt;
      snap_stk_r   <= stk_nxt;
      snap_ent_r   <= ent_nxt;
      snap_prog_r  <= prog_nxt;
    end
  end

  logic [31:0] computed;
  logic [30:0] need;

  always_comb begin
    computed = (snap_vlen_r != '0) ? ~snap_acc_r : ALL_ONES;
    need     = (snap_words_r < BLANK_W) ? BLANK_W : snap_words_r;
    if (snap_hcrc_r == ALL_ONES) begin
      verdict.status = ST_CRC_BLANK;
    end else if (snap_vlen_r == '0) begin
      verdict.status = ST_BAD_LENGTH;
    end else if (computed != snap_hcrc_r) begin
      verdict.status = ST_MISMATCH;
    end else if (!snap_stk_r) begin
      verdict.status = ST_STACK;
    end else if (!snap_ent_r) begin
      verdict.status = ST_ENTRY;
    end else if (!snap_prog_r) begin
      verdict.status = ST_BLANK;
    end else if (31'(snap_cnt_r) < need) begin
      verdict.status = ST_SHORT;
    end else begin
      verdict.status = ST_OK;
    end
    verdict.image_valid  = (verdict.status == ST_OK);
    verdict.computed_crc = computed;
    verdict.app_length   = snap_vlen_r;
  end

  always_comb begin
    snap_v_nxt = snap_v_r;
    if (fire_last) begin
      snap_v_nxt = 1'b1;
    end else if (snap_moves) begin
      snap_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (snap_moves) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      snap_v_r    <= snap_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_moves) begin
      out_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ===== sim/firmware_image_validator_tb.sv =====
// ----------------------------------------------------------------------------
// firmware_image_validator_tb
// Streams stored images (length word, CRC word, image words) through the
// validator under random valid/ready gaps. A local model of the CRC and
// range checks predicts every verdict, and the monitor compares each one
// field by field. Several register settings are exercised, including one
// where erased images pass the stack and entry checks.
// ----------------------------------------------------------------------------
module firmware_image_validator_tb;
  import fiv_pkg::*;

  localparam int unsigned     CNT_W       = 20;
  localparam int unsigned     BLANK_WORDS = 8;
  localparam logic [CNT_W-1:0] CNT_TOP    = '1;
  localparam logic [1:0]      OP_UNUSED   = 2'd3;
  localparam int unsigned     IDLE_PCT    = 12;
  localparam int unsigned     HOLD_CYCLES = 300;
  localparam int unsigned     DRAIN_LIMIT = 50000;

  typedef enum {
    FLT_NONE, FLT_CRC_BLANK, FLT_BAD_LEN, FLT_MISMATCH, FLT_STACK, FLT_ENTRY, FLT_BLANK
  } flaw_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  fiv_in_t              in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  fiv_out_t             out_item;

  firmware_image_validator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // register copies, reset values
  logic [31:0] reg_region     = 32'd491520;
  logic [31:0] reg_app_base   = 32'h0800_8000;
  logic [31:0] reg_flash_span = 32'h0010_0000;
  logic [31:0] reg_ram_base   = 32'h2000_0000;
  logic [31:0] reg_ram_span   = 32'h0002_0000;

  // image stream state
  logic [31:0]      img_crc        = ALL_ONES;
  logic [CNT_W-1:0] img_count      = '0;
  logic [31:0]      held_len       = '0;
  logic [31:0]      stored_crc     = ALL_ONES;
  logic             sp_ok          = 1'b0;
  logic             pc_ok          = 1'b0;
  logic             any_programmed = 1'b0;

  fiv_in_t  pending_items[$];
  fiv_out_t verdicts_due[$];
  int       errors       = 0;
  int       items_queued = 0;
  logic     quiet        = 1'b0;
  int       hold_req     = 0;
  int       hold_ack     = 0;
  int       hold_left    = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] crc32_word(logic [31:0] acc, logic [31:0] w);
    logic [31:0] a;
    a = acc ^ w;
    for (int i = 0; i < 32; i++) begin
      a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
    end
    return a;
  endfunction

  function automatic logic [31:0] checked_length(logic [31:0] len);
    if (len == ALL_ONES || reg_region < 32'd4 || len > reg_region - 32'd4) begin
      return '0;
    end
    return len;
  endfunction

  function automatic logic [32:0] word_span(logic [31:0] len);
    return {3'b000, len[31:2]} + 33'(len[1:0] != 2'b00);
  endfunction

  task automatic restart_image();
    img_crc        = ALL_ONES;
    img_count      = '0;
    held_len       = '0;
    stored_crc     = ALL_ONES;
    sp_ok          = 1'b0;
    pc_ok          = 1'b0;
    any_programmed = 1'b0;
  endtask

  // advance the image state by one accepted item; queue a verdict on last
  task automatic fold_item(fiv_in_t it);
    fiv_out_t    v;
    logic [31:0] len;
    logic [31:0] w;
    logic [32:0] need;
    w = it.data_word;
    case (it.operation)
      OP_LENGTH: held_len = w;
      OP_CRC:    stored_crc = w;
      OP_IMAGE: begin
        if (img_count != CNT_TOP) begin
          if (33'(img_count) < word_span(checked_length(held_len))) begin
            img_crc = crc32_word(img_crc, w);
          end
          if (img_count == 0) begin
            sp_ok = (w >= reg_ram_base) &&
                    ({1'b0, w} <= {1'b0, reg_ram_base} + {1'b0, reg_ram_span});
          end
          if (img_count == 1) begin
            pc_ok = (w >= reg_app_base) &&
                    ({1'b0, w} < {1'b0, reg_app_base} + {1'b0, reg_flash_span});
          end
          if (img_count < BLANK_WORDS && w != ALL_ONES) begin
            any_programmed = 1'b1;
          end
          img_count = img_count + 1'b1;
        end
      end
      default: ;
    endcase
    if (it.last) begin
      len            = checked_length(held_len);
      v.computed_crc = (len != 0) ? ~img_crc : ALL_ONES;
      v.app_length   = len;
      need           = word_span(len);
      if (need < 33'(BLANK_WORDS)) begin
        need = 33'(BLANK_WORDS);
      end
      if (stored_crc == ALL_ONES) begin
        v.status = ST_CRC_BLANK;
      end else if (len == 0) begin
        v.status = ST_BAD_LENGTH;
      end else if (v.computed_crc != stored_crc) begin
        v.status = ST_MISMATCH;
      end else if (!sp_ok) begin
        v.status = ST_STACK;
      end else if (!pc_ok) begin
        v.status = ST_ENTRY;
      end else if (!any_programmed) begin
        v.status = ST_BLANK;
      end else if (33'(img_count) < need) begin
        v.status = ST_SHORT;
      end else begin
        v.status = ST_OK;
      end
      v.image_valid = (v.status == ST_OK);
      verdicts_due.push_back(v);
      restart_image();
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic send(logic [1:0] op, logic [31:0] w, logic lst);
    fiv_in_t it;
    it.operation = op;
    it.data_word = w;
    it.last      = lst;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // one stored image: length, CRC, then nsent image words, last on the final one
  task automatic queue_image(logic [31:0] len, int nsent, flaw_t flaw);
    logic [31:0] img[$];
    logic [31:0] hi;
    logic [31:0] crc;
    logic [32:0] top;
    logic [32:0] nw;
    for (int i = 0; i < nsent; i++) begin
      img.push_back(($urandom_range(7) == 0) ? ALL_ONES : $urandom);
    end
    if (nsent > 0) begin
      top = {1'b0, reg_ram_base} + {1'b0, reg_ram_span};
      hi  = top[32] ? ALL_ONES : top[31:0];
      if (flaw == FLT_STACK) begin
        if (reg_ram_base != 0 && $urandom_range(1)) begin
          img[0] = reg_ram_base - 1;
        end else if (!top[32] && top[31:0] != ALL_ONES) begin
          img[0] = top[31:0] + 1;
        end else if (reg_ram_base != 0) begin
          img[0] = reg_ram_base - 1;
        end
      end else begin
        case ($urandom_range(2))
          0:       img[0] = reg_ram_base;
          1:       img[0] = hi;
          default: img[0] = $urandom_range(hi, reg_ram_base);
        endcase
      end
    end
    if (nsent > 1) begin
      top = {1'b0, reg_app_base} + {1'b0, reg_flash_span};
      hi  = top[32] ? ALL_ONES : top[31:0] - 1;
      if (flaw == FLT_ENTRY) begin
        if (reg_app_base != 0 && $urandom_range(1)) begin
          img[1] = reg_app_base - 1;
        end else if (!top[32]) begin
          img[1] = top[31:0];
        end else begin
          img[1] = reg_app_base - 1;
        end
      end else if (reg_flash_span != 0) begin
        case ($urandom_range(2))
          0:       img[1] = reg_app_base;
          1:       img[1] = hi;
          default: img[1] = $urandom_range(hi, reg_app_base);
        endcase
      end
    end
    if (flaw == FLT_BLANK) begin
      for (int i = 0; i < nsent && i < BLANK_WORDS; i++) begin
        img[i] = ALL_ONES;
      end
    end
    if (flaw == FLT_BAD_LEN) begin
      case ($urandom_range(2))
        0:       len = ALL_ONES;
        1:       len = '0;
        default: len = reg_region - 32'd3;
      endcase
    end
    nw  = word_span(checked_length(len));
    crc = ALL_ONES;
    for (int i = 0; i < nsent; i++) begin
      if (33'(i) < nw) begin
        crc = crc32_word(crc, img[i]);
      end
    end
    crc = ~crc;
    if (flaw == FLT_CRC_BLANK) begin
      crc = ALL_ONES;
    end else if (flaw == FLT_MISMATCH) begin
      crc = crc ^ (32'h1 << $urandom_range(31));
    end
    // the two header words may come in either order
    if ($urandom_range(9) == 0) begin
      send(OP_CRC, crc, 1'b0);
      send(OP_LENGTH, len, nsent == 0);
    end else begin
      send(OP_LENGTH, len, 1'b0);
      send(OP_CRC, crc, nsent == 0);
    end
    for (int i = 0; i < nsent; i++) begin
      send(OP_IMAGE, img[i], i == nsent - 1);
    end
  endtask

  task automatic random_image();
    logic [31:0] len;
    logic [32:0] need;
    int          r;
    int          nsent;
    flaw_t       flaw;
    r = $urandom_range(99);
    if (r < 80) begin
      len = $urandom_range(40, 1);
    end else if (r < 90) begin
      len = reg_region - 32'd4;
    end else begin
      len = $urandom;
    end
    need = word_span(checked_length(len));
    if (need < 33'(BLANK_WORDS)) begin
      need = 33'(BLANK_WORDS);
    end
    if (need > 33'd12) begin
      nsent = $urandom_range(12);
    end else if ($urandom_range(9) == 0) begin
      nsent = $urandom_range(int'(need) - 1);
    end else begin
      nsent = int'(need) + $urandom_range(2);
    end
    flaw = ($urandom_range(99) < 55) ? FLT_NONE : flaw_t'($urandom_range(6, 1));
    queue_image(len, nsent, flaw);
  endtask

  task automatic noise_item();
    send(2'($urandom_range(3)), ($urandom_range(3) == 0) ? ALL_ONES : $urandom,
         $urandom_range(5) == 0);
  endtask

  task automatic run_phase(int count);
    int target;
    target = items_queued + count;
    while (items_queued < target) begin
      if ($urandom_range(9) == 0) begin
        noise_item();
      end else begin
        random_image();
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // idle the block, then let items that cause no verdict flush out
  task automatic settle();
    wait_drained();
    repeat (6) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_REGION_SIZE: reg_region = val;
      CFG_APP_BASE:    reg_app_base = val;
      CFG_FLASH_SPAN:  reg_flash_span = val;
      CFG_RAM_BASE:    reg_ram_base = val;
      CFG_RAM_SPAN:    reg_ram_span = val;
      default: ;
    endcase
  endtask

  task automatic regs_done();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // sender: hold the item until taken, then pull the next one from the queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fold_item(in_item);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    fiv_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        report("verdict with none due, status", 32'(out_item.status), '0);
      end else begin
        want = verdicts_due.pop_front();
        if (out_item.image_valid !== want.image_valid) begin
          report("image_valid", 32'(out_item.image_valid), 32'(want.image_valid));
        end
        if (out_item.status !== want.status) begin
          report("status", 32'(out_item.status), 32'(want.status));
        end
        if (out_item.computed_crc !== want.computed_crc) begin
          report("computed_crc", out_item.computed_crc, want.computed_crc);
        end
        if (out_item.app_length !== want.app_length) begin
          report("app_length", out_item.app_length, want.app_length);
        end
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("firmware_image_validator verification failed");
    $finish;
  end

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: passing image, lone unused op, four failing checks, short stream
    queue_image(32'd1, 8, FLT_NONE);
    send(OP_UNUSED, ALL_ONES, 1'b1);
    queue_image(32'd4, 1, FLT_STACK);
    queue_image(32'd8, 2, FLT_ENTRY);
    queue_image(32'd4, 0, FLT_BAD_LEN);
    queue_image(32'd4, 1, FLT_MISMATCH);
    queue_image(reg_region - 32'd4, 2, FLT_NONE);
    run_phase(300);

    // fill the block while the receiver holds off
    @(negedge clk);
    hold_req <= hold_req + 1;
    for (int i = 0; i < 40; i++) begin
      send(2'($urandom_range(3)), $urandom, 1'b1);
    end
    wait_drained();
    run_phase(150);

    // low extremes: no room for a length, single-address stack and entry
    settle();
    set_reg(CFG_REGION_SIZE, '0);
    set_reg(CFG_APP_BASE, '0);
    set_reg(CFG_FLASH_SPAN, 32'd1);
    set_reg(CFG_RAM_BASE, '0);
    set_reg(CFG_RAM_SPAN, '0);
    regs_done();
    run_phase(80);

    // high extremes: erased words pass stack and entry, so blank is reachable
    settle();
    set_reg(CFG_REGION_SIZE, ALL_ONES);
    set_reg(CFG_APP_BASE, ALL_ONES);
    set_reg(CFG_FLASH_SPAN, ALL_ONES);
    set_reg(CFG_RAM_BASE, 32'hFFFF_0000);
    set_reg(CFG_RAM_SPAN, ALL_ONES);
    regs_done();
    queue_image(32'd32, 8, FLT_BLANK);
    queue_image(32'd12, 9, FLT_BLANK);
    run_phase(180);

    // typical layout, first part with no idling on either side
    settle();
    set_reg(CFG_REGION_SIZE, 32'd64);
    set_reg(CFG_APP_BASE, 32'h0800_0000);
    set_reg(CFG_FLASH_SPAN, 32'h0008_0000);
    set_reg(CFG_RAM_BASE, 32'h2000_0000);
    set_reg(CFG_RAM_SPAN, 32'h0000_5000);
    regs_done();
    quiet <= 1'b1;
    run_phase(180);
    wait_drained();
    quiet <= 1'b0;
    run_phase(170);

    settle();
    set_reg(CFG_REGION_SIZE, 32'd4);
    regs_done();
    run_phase(50);

    waited = 0;
    while ((pending_items.size() != 0 || in_valid || verdicts_due.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      report("verdicts never delivered", 32'(verdicts_due.size()), '0);
    end
    if (errors == 0) begin
      $display("firmware_image_validator verification clean");
    end else begin
      $display("firmware_image_validator verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fiv_pkg.sv
rtl/fiv_front.sv
rtl/fiv_queue.sv
rtl/fiv_back.sv
rtl/firmware_image_validator.sv
sim/firmware_image_validator_tb.sv
